>>> hdl/lorenz_euler_step_float_defines.svh
// Assertion macros used by the checker file.
`ifndef LORENZ_EULER_STEP_FLOAT_DEFINES_SVH
`define LORENZ_EULER_STEP_FLOAT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define LES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication with the consequent checked in the next cycle.
`define LES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// Types, constants and float helpers for the Lorenz Euler integrator.
// ----------------------------------------------------------------------------
package les_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [31:0] SgnBit = 32'h8000_0000;
    localparam logic [31:0] MaxMag = 32'h7FFF_FFFF;
    localparam logic [22:0] ManMask = 23'h7F_FFFF;
    localparam logic signed [10:0] ExpBias = 11'sd127;
    localparam logic signed [10:0] ExpMax = 11'sd254;

    localparam logic [31:0] SigmaReset = 32'h4120_0000;
    localparam logic [31:0] RhoReset = 32'h41E0_0000;
    localparam logic [31:0] BetaReset = 32'h402A_AAAB;
    localparam logic [31:0] StepReset = 32'h3C23_D70A;
    localparam logic [31:0] OneReset = 32'h3F80_0000;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CfgSigma = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgRho = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgBeta = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgStep = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgStartX = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CfgStartY = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CfgStartZ = 3'd6;

    // Operand sources of the shared units.
    typedef enum logic [3:0] {
        SRC_X, SRC_Y, SRC_Z, SRC_SIGMA, SRC_RHO, SRC_BETA, SRC_STEP,
        SRC_T0, SRC_T1, SRC_T2, SRC_T3
    } t_src;

    // Destinations of a result.
    typedef enum logic [2:0] {
        DST_T0, DST_T1, DST_T2, DST_T3, DST_X, DST_Y, DST_Z
    } t_dst;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_MUL2, ST_ADD2, ST_WRITE, ST_OUT
    } t_state;

    // One micro-operation: operation class, operands and destination.
    typedef struct packed {
        logic is_mul;
        logic sub;
        t_src a;
        t_src b;
        t_dst d;
    } t_uop;

    localparam int unsigned NumUops = 14;
    localparam int unsigned UopIdxWidth = 4;

    function automatic t_uop uop_rom(input logic [UopIdxWidth-1:0] idx);
        t_uop u;
        u = '{1'b0, 1'b0, SRC_X, SRC_X, DST_T0};
        unique case (idx)
            4'd0: u = '{1'b0, 1'b1, SRC_Y, SRC_X, DST_T0};
            4'd1: u = '{1'b1, 1'b0, SRC_SIGMA, SRC_T0, DST_T0};
            4'd2: u = '{1'b1, 1'b0, SRC_T0, SRC_STEP, DST_T0};
            4'd3: u = '{1'b0, 1'b1, SRC_RHO, SRC_Z, DST_T1};
            4'd4: u = '{1'b1, 1'b0, SRC_T1, SRC_X, DST_T1};
            4'd5: u = '{1'b0, 1'b1, SRC_T1, SRC_Y, DST_T1};
            4'd6: u = '{1'b1, 1'b0, SRC_T1, SRC_STEP, DST_T1};
            4'd7: u = '{1'b1, 1'b0, SRC_X, SRC_Y, DST_T2};
            4'd8: u = '{1'b1, 1'b0, SRC_BETA, SRC_Z, DST_T3};
            4'd9: u = '{1'b0, 1'b1, SRC_T2, SRC_T3, DST_T2};
            4'd10: u = '{1'b1, 1'b0, SRC_T2, SRC_STEP, DST_T2};
            4'd11: u = '{1'b0, 1'b0, SRC_X, SRC_T0, DST_X};
            4'd12: u = '{1'b0, 1'b0, SRC_Y, SRC_T1, DST_Y};
            4'd13: u = '{1'b0, 1'b0, SRC_Z, SRC_T2, DST_Z};
            default: u = '{1'b0, 1'b0, SRC_X, SRC_X, DST_T0};
        endcase
        return u;
    endfunction

    // Final packing with overflow saturation and underflow to signed zero.
    function automatic logic [31:0] pack(input logic sign, input logic signed [10:0] e,
                                         input logic [22:0] m);
        logic [31:0] r;
        if (e > ExpMax) begin
            r = {sign, MaxMag[30:0]};
        end else if (e < 0) begin
            r = {sign, 31'd0};
        end else begin
            r = {sign, e[7:0], m & ManMask};
        end
        return r;
    endfunction

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic stage2;
        logic write;
        logic [UopIdxWidth-1:0] idx;
    } t_cmd;

endpackage

>>> hdl/les_datapath.sv
// ----------------------------------------------------------------------------
// les_datapath
// Shared truncating float adder and multiplier, state and scratch registers.
// ----------------------------------------------------------------------------
module les_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  les_pkg::t_cmd     i_cmd,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output logic [31:0]       o_x,
    output logic [31:0]       o_y,
    output logic [31:0]       o_z
);

    logic [31:0] r_sigma, r_rho, r_beta, r_step, r_sx, r_sy, r_sz;
    logic [31:0] r_x, r_y, r_z;
    logic [31:0] r_t0, r_t1, r_t2, r_t3;
    logic [31:0] r_opa, r_opb;
    les_pkg::t_uop r_uop;
    les_pkg::t_uop w_uop;
    logic [31:0] w_a, w_b;

    // First stage registers (adder alignment or raw product).
    logic        r_s_sign;
    logic signed [10:0] r_s_e;
    logic [24:0] r_s_m;
    logic        r_s_eff_sub;
    logic [47:0] r_prod;

    assign w_uop = les_pkg::uop_rom(i_cmd.idx);

    function automatic logic [31:0] sel(input les_pkg::t_src s,
                                        input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z, input logic [31:0] sg,
                                        input logic [31:0] rh, input logic [31:0] bt,
                                        input logic [31:0] st, input logic [31:0] t0,
                                        input logic [31:0] t1, input logic [31:0] t2,
                                        input logic [31:0] t3);
        logic [31:0] r;
        unique case (s)
            les_pkg::SRC_X: r = x;
            les_pkg::SRC_Y: r = y;
            les_pkg::SRC_Z: r = z;
            les_pkg::SRC_SIGMA: r = sg;
            les_pkg::SRC_RHO: r = rh;
            les_pkg::SRC_BETA: r = bt;
            les_pkg::SRC_STEP: r = st;
            les_pkg::SRC_T0: r = t0;
            les_pkg::SRC_T1: r = t1;
            les_pkg::SRC_T2: r = t2;
            les_pkg::SRC_T3: r = t3;
            default: r = x;
        endcase
        return r;
    endfunction

    assign w_a = sel(w_uop.a, r_x, r_y, r_z, r_sigma, r_rho, r_beta, r_step,
                     r_t0, r_t1, r_t2, r_t3);
    assign w_b = sel(w_uop.b, r_x, r_y, r_z, r_sigma, r_rho, r_beta, r_step,
                     r_t0, r_t1, r_t2, r_t3);

    // Adder stage one: align and add or subtract magnitudes.
    logic [7:0]  w_ea, w_eb, w_d;
    logic [23:0] w_ma, w_mb, w_mas, w_mbs;
    logic        w_sa, w_sb;
    logic [7:0]  w_e1;
    logic [24:0] w_sum;
    logic        w_sgn1;

    always_comb begin
        w_ea = r_opa[30:23];
        w_eb = r_opb[30:23];
        w_ma = {1'b1, r_opa[22:0]};
        w_mb = {1'b1, r_opb[22:0]};
        w_sa = r_opa[31];
        w_sb = r_opb[31] ^ r_uop.sub;
        w_mas = w_ma;
        w_mbs = w_mb;
        w_e1 = w_ea;
        w_d = 8'd0;
        if (w_ea > w_eb) begin
            w_d = w_ea - w_eb;
            w_mbs = (w_d >= 8'd24) ? 24'd0 : (w_mb >> w_d);
        end else if (w_eb > w_ea) begin
            w_d = w_eb - w_ea;
            w_mas = (w_d >= 8'd24) ? 24'd0 : (w_ma >> w_d);
            w_e1 = w_eb;
        end
        w_sgn1 = 1'b0;
        if (w_sa == w_sb) begin
            w_sum = {1'b0, w_mas} + {1'b0, w_mbs};
            w_sgn1 = w_sa;
        end else if (w_sb) begin
            w_sum = {1'b0, w_mas} - {1'b0, w_mbs};
        end else begin
            w_sum = {1'b0, w_mbs} - {1'b0, w_mas};
        end
        if ((w_sa != w_sb) && w_sum[24]) begin
            // Negative difference: take the magnitude.
            w_sum = 25'd0 - w_sum;
            w_sgn1 = 1'b1;
        end
    end

    // Adder stage two: normalize and pack.
    logic [4:0]  w_lz;
    logic [23:0] w_nm;
    logic signed [10:0] w_ne;
    logic [31:0] w_add_res;

    always_comb begin
        w_lz = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (r_s_m[i]) begin
                w_lz = 5'(23 - i);
            end
        end
        w_nm = 24'd0;
        w_ne = r_s_e;
        w_add_res = 32'd0;
        if (!r_s_eff_sub) begin
            if (r_s_m[24]) begin
                w_add_res = les_pkg::pack(r_s_sign, r_s_e + 11'sd1, r_s_m[23:1]);
            end else begin
                w_add_res = les_pkg::pack(r_s_sign, r_s_e, r_s_m[22:0]);
            end
        end else if (r_s_m[23:0] == 24'd0) begin
            w_add_res = les_pkg::pack(r_s_sign, 11'sd0, 23'd0);
        end else begin
            w_nm = r_s_m[23:0] << w_lz;
            w_ne = r_s_e - 11'(w_lz);
            w_add_res = les_pkg::pack(r_s_sign, w_ne, w_nm[22:0]);
        end
    end

    // Multiplier stage two: normalize the product.
    logic [31:0] w_mul_res;
    logic signed [10:0] w_me;
    logic [31:0] w_res;

    always_comb begin
        w_me = 11'(r_opa[30:23]) + 11'(r_opb[30:23]) - les_pkg::ExpBias;
        if (r_prod[47]) begin
            w_mul_res = les_pkg::pack(r_opa[31] ^ r_opb[31], w_me + 11'sd1, r_prod[46:24]);
        end else begin
            w_mul_res = les_pkg::pack(r_opa[31] ^ r_opb[31], w_me, r_prod[45:23]);
        end
    end

    assign w_res = r_uop.is_mul ? w_mul_res : w_add_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_opa <= w_a;
            r_opb <= w_b;
            r_uop <= w_uop;
        end
        if (i_cmd.stage2) begin
            r_s_sign <= w_sgn1;
            r_s_e <= 11'(w_e1);
            r_s_m <= w_sum;
            r_s_eff_sub <= (w_sa != w_sb);
            r_prod <= {24'd0, 1'b1, r_opa[22:0]} * {24'd0, 1'b1, r_opb[22:0]};
        end
        if (i_cmd.write) begin
            unique case (r_uop.d)
                les_pkg::DST_T0: r_t0 <= w_res;
                les_pkg::DST_T1: r_t1 <= w_res;
                les_pkg::DST_T2: r_t2 <= w_res;
                les_pkg::DST_T3: r_t3 <= w_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= les_pkg::OneReset;
            r_y <= les_pkg::OneReset;
            r_z <= les_pkg::OneReset;
        end else if (i_cmd.load) begin
            r_x <= r_sx;
            r_y <= r_sy;
            r_z <= r_sz;
        end else if (i_cmd.write) begin
            unique case (r_uop.d)
                les_pkg::DST_X: r_x <= w_res;
                les_pkg::DST_Y: r_y <= w_res;
                les_pkg::DST_Z: r_z <= w_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= les_pkg::SigmaReset;
            r_rho <= les_pkg::RhoReset;
            r_beta <= les_pkg::BetaReset;
            r_step <= les_pkg::StepReset;
            r_sx <= les_pkg::OneReset;
            r_sy <= les_pkg::OneReset;
            r_sz <= les_pkg::OneReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                les_pkg::CfgSigma: r_sigma <= i_cfg_data;
                les_pkg::CfgRho: r_rho <= i_cfg_data;
                les_pkg::CfgBeta: r_beta <= i_cfg_data;
                les_pkg::CfgStep: r_step <= i_cfg_data;
                les_pkg::CfgStartX: r_sx <= i_cfg_data;
                les_pkg::CfgStartY: r_sy <= i_cfg_data;
                les_pkg::CfgStartZ: r_sz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

>>> hdl/les_ctrl.sv
// ----------------------------------------------------------------------------
// les_ctrl
// Sequencer that walks the fourteen float operations of one Euler step.
// ----------------------------------------------------------------------------
module les_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_restart,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output les_pkg::t_cmd o_cmd
);

    les_pkg::t_state r_state, n_state;
    logic [les_pkg::UopIdxWidth-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= les_pkg::ST_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        unique case (r_state)
            les_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx = '0;
                    n_state = i_restart ? les_pkg::ST_OUT : les_pkg::ST_ISSUE;
                end
            end
            les_pkg::ST_ISSUE: n_state = les_pkg::ST_MUL2;
            les_pkg::ST_MUL2: n_state = les_pkg::ST_ADD2;
            les_pkg::ST_ADD2: n_state = les_pkg::ST_WRITE;
            les_pkg::ST_WRITE: begin
                if (r_idx == les_pkg::UopIdxWidth'(les_pkg::NumUops - 1)) begin
                    n_state = les_pkg::ST_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = les_pkg::ST_ISSUE;
                end
            end
            les_pkg::ST_OUT: if (i_out_ready) n_state = les_pkg::ST_IDLE;
            default: n_state = les_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == les_pkg::ST_IDLE);
        o_out_valid = (r_state == les_pkg::ST_OUT);
        o_cmd.load = (r_state == les_pkg::ST_IDLE) && i_in_valid && i_restart;
        o_cmd.issue = (r_state == les_pkg::ST_ISSUE);
        o_cmd.stage2 = (r_state == les_pkg::ST_MUL2);
        o_cmd.write = (r_state == les_pkg::ST_WRITE);
        o_cmd.idx = r_idx;
    end

endmodule

>>> hdl/lorenz_euler_step_float.sv
// ----------------------------------------------------------------------------
// lorenz_euler_step_float
// Forward-Euler Lorenz integrator on truncating single-precision floats.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one restart bit per transfer. With restart high
// the start point is loaded and shown; with restart low one Euler step runs.
// The output channel shows the new x, y, z after each input transfer.
// An Euler step is fourteen float operations on one shared adder and one
// shared multiplier, each passing through operand fetch, first stage, second
// stage and write back. A restart shows its point in the cycle after the input
// transfer. One item is in flight at a time and the next input is taken in
// the cycle after the output transfer.
// Reset loads the default coefficients and the point (1, 1, 1).
// While the receiver stalls the result is held and no input is taken.
// Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module lorenz_euler_step_float (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [les_pkg::DataWidth-1:0] o_x_out,
    output logic [les_pkg::DataWidth-1:0] o_y_out,
    output logic [les_pkg::DataWidth-1:0] o_z_out,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [les_pkg::DataWidth-1:0] i_cfg_data
);

    les_pkg::t_cmd w_cmd;

    les_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_restart),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    les_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_x        (o_x_out),
        .o_y        (o_y_out),
        .o_z        (o_z_out)
    );

endmodule

>>> hdl/les_checker.sv
// ----------------------------------------------------------------------------
// les_checker
// Port-level checks of the integrator's handshake and sequencing.
// ----------------------------------------------------------------------------
`include "lorenz_euler_step_float_defines.svh"

module les_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_restart,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_x_out
);

    // The block never takes input while a result is on show.
    `LES_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    // A stalled result keeps its value.
    `LES_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_x_out))
    // A restart transfer shows its point in the next cycle.
    `LES_ASSERT_NEXT(a_rst_lat, i_clk, i_rst_n, i_in_valid && o_in_ready && i_restart,
        o_out_valid)
    // After an output transfer the block is ready again.
    `LES_ASSERT_NEXT(a_back, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready)

endmodule

bind lorenz_euler_step_float les_checker u_les_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_restart   (i_restart),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_x_out     (o_x_out)
);
